// ===== hw/rtl/mvp_pkg.sv =====
// ----------------------------------------------------------------------------
// mvp_pkg: shared types, constants and functions of the frame parser
// Byte classes passed from the front to the back, phase codes, the
// CRC-16/X.25 byte step and the per-message CRC extra table.
// ----------------------------------------------------------------------------
package mvp_pkg;

    // framing constants
    localparam logic [7:0]  START_BYTE  = 8'hFD;
    localparam logic [15:0] CRC_SEED    = 16'hFFFF;
    localparam logic [23:0] CMD_LONG_ID = 24'd76;
    localparam logic [7:0]  CMD_MIN_LEN = 8'd31;
    localparam logic [7:0]  CMD_OFFSET  = 8'd28;
    localparam logic [7:0]  PARAM_BYTES = 8'd4;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // receive phase, one-hot
    typedef enum logic [12:0] {
        PH_IDLE     = 13'b0000000000001,
        PH_LEN      = 13'b0000000000010,
        PH_INCOMPAT = 13'b0000000000100,
        PH_COMPAT   = 13'b0000000001000,
        PH_SEQ      = 13'b0000000010000,
        PH_SYS      = 13'b0000000100000,
        PH_COMP     = 13'b0000001000000,
        PH_MID0     = 13'b0000010000000,
        PH_MID1     = 13'b0000100000000,
        PH_MID2     = 13'b0001000000000,
        PH_PAYLOAD  = 13'b0010000000000,
        PH_CRCLO    = 13'b0100000000000,
        PH_CRCHI    = 13'b1000000000000
    } phase_t;

    // byte class handed to the back
    typedef enum logic [3:0] {
        K_START   = 4'd0,
        K_LEN     = 4'd1,
        K_SEQ     = 4'd2,
        K_SYS     = 4'd3,
        K_COMP    = 4'd4,
        K_MID0    = 4'd5,
        K_MID1    = 4'd6,
        K_MID2    = 4'd7,
        K_PAYLOAD = 4'd8,
        K_EMIT    = 4'd9
    } kind_t;

    // one queue entry
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } entry_t;

    // one CRC-16/X.25 step over a byte
    function automatic logic [15:0] x25_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
               ^ {12'h000, t[7:4]};
    endfunction

    // per-message CRC extra byte
    function automatic logic [7:0] crc_extra(input logic [23:0] id);
        logic [7:0] e;
        unique case (id)
            24'd0:   e = 8'd50;
            24'd24:  e = 8'd24;
            24'd30:  e = 8'd39;
            24'd33:  e = 8'd104;
            24'd65:  e = 8'd118;
            24'd76:  e = 8'd152;
            24'd147: e = 8'd154;
            default: e = 8'd0;
        endcase
        return e;
    endfunction

endpackage

// ===== hw/rtl/mvp_front.sv =====
// ----------------------------------------------------------------------------
// mvp_front: byte classifier of the frame parser
// Tracks the receive phase, runs the CRC and the length count, and pushes
// one classified entry per byte that the back needs, plus an emit entry
// for each frame whose CRC checks good.
// ----------------------------------------------------------------------------
module mvp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       rx_byte,
    input  logic             queue_full,
    output logic             push_valid,
    output mvp_pkg::entry_t  push_entry
);

    mvp_pkg::phase_t phase_reg, phase_next;
    logic [15:0]     crc_reg, crc_next;
    logic [7:0]      len_reg, len_next;
    logic [7:0]      idx_reg, idx_next;
    logic [23:0]     mid_reg, mid_next;

    logic            take;
    logic [15:0]     crc_byte;
    logic [15:0]     crc_fin;

    assign in_ready = ~queue_full;
    assign take     = in_valid & in_ready;

    // crc over the incoming byte and over the extra byte
    assign crc_byte = mvp_pkg::x25_step(crc_reg, rx_byte);
    assign crc_fin  = mvp_pkg::x25_step(crc_reg, mvp_pkg::crc_extra(mid_reg));

    // phase sequencing and classification
    always_comb
    begin
        phase_next       = phase_reg;
        crc_next         = crc_reg;
        len_next         = len_reg;
        idx_next         = idx_reg;
        mid_next         = mid_reg;
        push_valid       = 1'b0;
        push_entry.kind  = mvp_pkg::K_START;
        push_entry.data  = rx_byte;
        if (take)
        begin
            unique case (phase_reg)
                mvp_pkg::PH_LEN:
                begin
                    len_next        = rx_byte;
                    crc_next        = crc_byte;
                    push_valid      = 1'b1;
                    push_entry.kind = mvp_pkg::K_LEN;
                    phase_next      = mvp_pkg::PH_INCOMPAT;
                end
                mvp_pkg::PH_INCOMPAT:
                begin
                    crc_next   = crc_byte;
                    phase_next = mvp_pkg::PH_COMPAT;
                end
                mvp_pkg::PH_COMPAT:
                begin
                    crc_next   = crc_byte;
                    phase_next = mvp_pkg::PH_SEQ;
                end
                mvp_pkg::PH_SEQ:
                begin
                    crc_next        = crc_byte;
                    push_valid      = 1'b1;
                    push_entry.kind = mvp_pkg::K_SEQ;
                    phase_next      = mvp_pkg::PH_SYS;
                end
                mvp_pkg::PH_SYS:
                begin
                    crc_next        = crc_byte;
                    push_valid      = 1'b1;
                    push_entry.kind = mvp_pkg::K_SYS;
                    phase_next      = mvp_pkg::PH_COMP;
                end
                mvp_pkg::PH_COMP:
                begin
                    crc_next        = crc_byte;
                    push_valid      = 1'b1;
                    push_entry.kind = mvp_pkg::K_COMP;
                    phase_next      = mvp_pkg::PH_MID0;
                end
                mvp_pkg::PH_MID0:
                begin
                    mid_next        = {16'h0000, rx_byte};
                    crc_next        = crc_byte;
                    push_valid      = 1'b1;
                    push_entry.kind = mvp_pkg::K_MID0;
                    phase_next      = mvp_pkg::PH_MID1;
                end
                mvp_pkg::PH_MID1:
                begin
                    mid_next        = {mid_reg[23:16], rx_byte, mid_reg[7:0]};
                    crc_next        = crc_byte;
                    push_valid      = 1'b1;
                    push_entry.kind = mvp_pkg::K_MID1;
                    phase_next      = mvp_pkg::PH_MID2;
                end
                mvp_pkg::PH_MID2:
                begin
                    mid_next        = {rx_byte, mid_reg[15:0]};
                    crc_next        = crc_byte;
                    push_valid      = 1'b1;
                    push_entry.kind = mvp_pkg::K_MID2;
                    phase_next      = (len_reg == 8'd0) ? mvp_pkg::PH_CRCLO
                                                        : mvp_pkg::PH_PAYLOAD;
                end
                mvp_pkg::PH_PAYLOAD:
                begin
                    crc_next        = crc_byte;
                    idx_next        = idx_reg + 8'd1;
                    push_valid      = 1'b1;
                    push_entry.kind = mvp_pkg::K_PAYLOAD;
                    if ({1'b0, idx_reg} + 9'd1 >= {1'b0, len_reg})
                    begin
                        phase_next = mvp_pkg::PH_CRCLO;
                    end
                end
                mvp_pkg::PH_CRCLO:
                begin
                    // mismatch drops the frame, this byte is not a start byte
                    if (crc_fin[7:0] != rx_byte)
                    begin
                        phase_next = mvp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        crc_next   = crc_fin;
                        phase_next = mvp_pkg::PH_CRCHI;
                    end
                end
                mvp_pkg::PH_CRCHI:
                begin
                    if (crc_reg[15:8] == rx_byte)
                    begin
                        push_valid      = 1'b1;
                        push_entry.kind = mvp_pkg::K_EMIT;
                    end
                    phase_next = mvp_pkg::PH_IDLE;
                end
                default:
                begin
                    // hunting for the start byte
                    phase_next = mvp_pkg::PH_IDLE;
                    if (rx_byte == mvp_pkg::START_BYTE)
                    begin
                        crc_next        = mvp_pkg::CRC_SEED;
                        idx_next        = 8'd0;
                        mid_next        = 24'd0;
                        push_valid      = 1'b1;
                        push_entry.kind = mvp_pkg::K_START;
                        phase_next      = mvp_pkg::PH_LEN;
                    end
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mvp_pkg::PH_IDLE;
            crc_reg   <= mvp_pkg::CRC_SEED;
            len_reg   <= 8'd0;
            idx_reg   <= 8'd0;
            mid_reg   <= 24'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            mid_reg   <= mid_next;
        end
    end

endmodule

// ===== hw/rtl/mvp_queue.sv =====
// ----------------------------------------------------------------------------
// mvp_queue: entry queue between front and back
// Small circular buffer of classified bytes; push and pop in the same
// cycle are allowed, also when full.
// ----------------------------------------------------------------------------
module mvp_queue #(
    parameter int DEPTH = mvp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  mvp_pkg::entry_t  push_entry,
    output logic             full,
    output logic             pop_valid,
    input  logic             pop_ready,
    output mvp_pkg::entry_t  pop_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    mvp_pkg::entry_t mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full      = (count_reg == FULL_COUNT);
    assign pop_valid = (count_reg != '0);
    assign pop_entry = mem[rd_ptr_reg];
    assign do_pop    = pop_valid & pop_ready;
    assign do_push   = push_valid & (~full | do_pop);

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/mvp_back.sv =====
// ----------------------------------------------------------------------------
// mvp_back: field capture and descriptor output of the frame parser
// Pops classified bytes, captures header fields and the command bytes,
// and loads the output register on each emit entry.
// ----------------------------------------------------------------------------
module mvp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  mvp_pkg::entry_t  pop_entry,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [23:0]      message_id,
    output logic [7:0]       sequence_res,
    output logic [7:0]       sender_system,
    output logic [7:0]       sender_component,
    output logic [7:0]       payload_length,
    output logic             command_valid,
    output logic [15:0]      command_code,
    output logic [31:0]      param1_bits
);

    // frame capture
    logic [7:0]  len_reg, len_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  sys_reg, sys_next;
    logic [7:0]  comp_reg, comp_next;
    logic [23:0] mid_reg, mid_next;
    logic [7:0]  idx_reg, idx_next;
    logic [15:0] cmd_reg, cmd_next;
    logic [31:0] param_reg, param_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [23:0] o_mid_reg, o_mid_next;
    logic [7:0]  o_seq_reg, o_seq_next;
    logic [7:0]  o_sys_reg, o_sys_next;
    logic [7:0]  o_comp_reg, o_comp_next;
    logic [7:0]  o_len_reg, o_len_next;
    logic        o_cv_reg, o_cv_next;
    logic [15:0] o_cmd_reg, o_cmd_next;
    logic [31:0] o_par_reg, o_par_next;

    logic        is_emit;
    logic        slot_free;
    logic        take;
    logic        is_cmd;
    logic [7:0]  b;

    assign b         = pop_entry.data;
    assign is_emit   = (pop_entry.kind == mvp_pkg::K_EMIT);
    assign slot_free = ~out_valid_reg | out_ready;
    assign pop_ready = ~is_emit | slot_free;
    assign take      = pop_valid & pop_ready;
    assign is_cmd    = (mid_reg == mvp_pkg::CMD_LONG_ID) && (len_reg >= mvp_pkg::CMD_MIN_LEN);

    // entry execution
    always_comb
    begin
        len_next       = len_reg;
        seq_next       = seq_reg;
        sys_next       = sys_reg;
        comp_next      = comp_reg;
        mid_next       = mid_reg;
        idx_next       = idx_reg;
        cmd_next       = cmd_reg;
        param_next     = param_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        o_mid_next     = o_mid_reg;
        o_seq_next     = o_seq_reg;
        o_sys_next     = o_sys_reg;
        o_comp_next    = o_comp_reg;
        o_len_next     = o_len_reg;
        o_cv_next      = o_cv_reg;
        o_cmd_next     = o_cmd_reg;
        o_par_next     = o_par_reg;
        if (take)
        begin
            unique case (pop_entry.kind)
                mvp_pkg::K_START:
                begin
                    idx_next   = 8'd0;
                    mid_next   = 24'd0;
                    cmd_next   = 16'h0000;
                    param_next = 32'h0000_0000;
                end
                mvp_pkg::K_LEN:  len_next  = b;
                mvp_pkg::K_SEQ:  seq_next  = b;
                mvp_pkg::K_SYS:  sys_next  = b;
                mvp_pkg::K_COMP: comp_next = b;
                mvp_pkg::K_MID0: mid_next  = {16'h0000, b};
                mvp_pkg::K_MID1: mid_next  = {mid_reg[23:16], b, mid_reg[7:0]};
                mvp_pkg::K_MID2: mid_next  = {b, mid_reg[15:0]};
                mvp_pkg::K_PAYLOAD:
                begin
                    // param1 bytes, then the command word
                    if (idx_reg < mvp_pkg::PARAM_BYTES)
                    begin
                        unique case (idx_reg[1:0])
                            2'd0:    param_next[7:0]   = b;
                            2'd1:    param_next[15:8]  = b;
                            2'd2:    param_next[23:16] = b;
                            default: param_next[31:24] = b;
                        endcase
                    end
                    else if (idx_reg == mvp_pkg::CMD_OFFSET)
                    begin
                        cmd_next[7:0] = b;
                    end
                    else if (idx_reg == mvp_pkg::CMD_OFFSET + 8'd1)
                    begin
                        cmd_next[15:8] = b;
                    end
                    idx_next = idx_reg + 8'd1;
                end
                mvp_pkg::K_EMIT:
                begin
                    out_valid_next = 1'b1;
                    o_mid_next     = mid_reg;
                    o_seq_next     = seq_reg;
                    o_sys_next     = sys_reg;
                    o_comp_next    = comp_reg;
                    o_len_next     = len_reg;
                    o_cv_next      = is_cmd;
                    o_cmd_next     = is_cmd ? cmd_reg : 16'h0000;
                    o_par_next     = is_cmd ? param_reg : 32'h0000_0000;
                end
                default:
                begin
                end
            endcase
        end
    end

    // control and capture registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            len_reg       <= 8'd0;
            seq_reg       <= 8'd0;
            sys_reg       <= 8'd0;
            comp_reg      <= 8'd0;
            mid_reg       <= 24'd0;
            idx_reg       <= 8'd0;
            cmd_reg       <= 16'h0000;
            param_reg     <= 32'h0000_0000;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            len_reg       <= len_next;
            seq_reg       <= seq_next;
            sys_reg       <= sys_next;
            comp_reg      <= comp_next;
            mid_reg       <= mid_next;
            idx_reg       <= idx_next;
            cmd_reg       <= cmd_next;
            param_reg     <= param_next;
        end
    end

    // descriptor payload
    always_ff @(posedge clk)
    begin
        o_mid_reg  <= o_mid_next;
        o_seq_reg  <= o_seq_next;
        o_sys_reg  <= o_sys_next;
        o_comp_reg <= o_comp_next;
        o_len_reg  <= o_len_next;
        o_cv_reg   <= o_cv_next;
        o_cmd_reg  <= o_cmd_next;
        o_par_reg  <= o_par_next;
    end

    assign out_valid        = out_valid_reg;
    assign message_id       = o_mid_reg;
    assign sequence_res     = o_seq_reg;
    assign sender_system    = o_sys_reg;
    assign sender_component = o_comp_reg;
    assign payload_length   = o_len_reg;
    assign command_valid    = o_cv_reg;
    assign command_code     = o_cmd_reg;
    assign param1_bits      = o_par_reg;

endmodule

// ===== hw/rtl/mavlink_v2_frame_parser_unit.sv =====
// ----------------------------------------------------------------------------
// mavlink_v2_frame_parser_unit: v2 receive frame parser with X.25 CRC check
// Hunts the start byte, checks the frame CRC with the per-message extra
// byte and emits one descriptor per good frame.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_ready  rx_byte
//   output    out        out_valid/out_ready  message_id .. param1_bits
//
// One byte per cycle is taken while in_ready is high; the front classifies a
// byte and updates the CRC in the cycle it is accepted, the back executes it
// from the queue and loads its output register on the emit entry that a good
// CRC high byte produces. in_ready drops only when the queue is full, which
// happens when the output register holds an untaken descriptor and the back stalls.
// Reset returns to hunting with an empty queue and no pending descriptor.
// ----------------------------------------------------------------------------
module mavlink_v2_frame_parser_unit #(
    parameter int QUEUE_DEPTH = mvp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] message_id,
    output logic [7:0]  sequence_res,
    output logic [7:0]  sender_system,
    output logic [7:0]  sender_component,
    output logic [7:0]  payload_length,
    output logic        command_valid,
    output logic [15:0] command_code,
    output logic [31:0] param1_bits
);

    logic            queue_full;
    logic            push_valid;
    mvp_pkg::entry_t push_entry;
    logic            pop_valid;
    logic            pop_ready;
    mvp_pkg::entry_t pop_entry;

    // byte classifier and crc
    mvp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    // queue between front and back
    mvp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // field capture and descriptor output
    mvp_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_entry        (pop_entry),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .message_id       (message_id),
        .sequence_res     (sequence_res),
        .sender_system    (sender_system),
        .sender_component (sender_component),
        .payload_length   (payload_length),
        .command_valid    (command_valid),
        .command_code     (command_code),
        .param1_bits      (param1_bits)
    );

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: frame parser check against a byte-level predictor
// Streams v2 frames (good, corrupted, cut short) and line noise into the
// parser with bursty input and a stalling output side. Every accepted byte
// advances a private model of the receive phases and the X.25 CRC; each
// descriptor the parser emits is compared field by field with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 500000;
    localparam int FRAME_BYTE_TARGET = 1700;
    localparam int DRAIN_CYCLES = 40;

    // message ids with a known crc extra byte
    localparam logic [23:0] MSG_HEARTBEAT   = 24'd0;
    localparam logic [23:0] MSG_GPS_RAW     = 24'd24;
    localparam logic [23:0] MSG_ATTITUDE    = 24'd30;
    localparam logic [23:0] MSG_GLOBAL_POS  = 24'd33;
    localparam logic [23:0] MSG_RC_CHANNELS = 24'd65;
    localparam logic [23:0] MSG_BATTERY     = 24'd147;

    // ways a transmitted frame can be damaged
    typedef enum int {
        FAULT_NONE,
        FAULT_LOW,
        FAULT_LOW_START,
        FAULT_HIGH,
        FAULT_FLIP,
        FAULT_CUT
    } fault_t;

    // one verified frame as seen on the output ports
    typedef struct packed {
        logic [23:0] msg;
        logic [7:0]  seq;
        logic [7:0]  sys;
        logic [7:0]  comp;
        logic [7:0]  len;
        logic        cmd_ok;
        logic [15:0] cmd;
        logic [31:0] param;
    } descriptor_t;

    // receive-side model and store of predicted descriptors
    class frame_scoreboard;
        descriptor_t      expected_q[$];
        int               error_count;
        mvp_pkg::phase_t  phase;
        logic [15:0]      crc;
        logic [7:0]       flen;
        logic [7:0]       pidx;
        logic [7:0]       fseq;
        logic [7:0]       fsys;
        logic [7:0]       fcomp;
        logic [23:0]      fmsg;
        logic [15:0]      cmd;
        logic [31:0]      param;

        function new();
            error_count = 0;
            phase = mvp_pkg::PH_IDLE;
            crc = mvp_pkg::CRC_SEED;
            flen = '0;
            pidx = '0;
            fseq = '0;
            fsys = '0;
            fcomp = '0;
            fmsg = '0;
            cmd = '0;
            param = '0;
        endfunction

        // reflected 0x1021 update over one byte
        function logic [15:0] crc_fold(logic [15:0] acc, logic [7:0] b);
            logic [15:0] t;
            t = {8'h00, b ^ acc[7:0]};
            t = (t ^ (t << 4)) & 16'h00FF;
            return (acc >> 8) ^ (t << 8) ^ (t << 3) ^ (t >> 4);
        endfunction

        function logic [7:0] extra_byte(logic [23:0] id);
            case (id)
                MSG_HEARTBEAT:        return 8'd50;
                MSG_GPS_RAW:          return 8'd24;
                MSG_ATTITUDE:         return 8'd39;
                MSG_GLOBAL_POS:       return 8'd104;
                MSG_RC_CHANNELS:      return 8'd118;
                mvp_pkg::CMD_LONG_ID: return 8'd152;
                MSG_BATTERY:          return 8'd154;
                default:              return 8'd0;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // advance the model by one accepted byte
        function void note_byte(logic [7:0] b);
            logic [15:0] c;
            descriptor_t d;
            case (phase)
                mvp_pkg::PH_LEN:
                begin
                    flen = b;
                    crc = crc_fold(crc, b);
                    phase = mvp_pkg::PH_INCOMPAT;
                end
                mvp_pkg::PH_INCOMPAT:
                begin
                    crc = crc_fold(crc, b);
                    phase = mvp_pkg::PH_COMPAT;
                end
                mvp_pkg::PH_COMPAT:
                begin
                    crc = crc_fold(crc, b);
                    phase = mvp_pkg::PH_SEQ;
                end
                mvp_pkg::PH_SEQ:
                begin
                    fseq = b;
                    crc = crc_fold(crc, b);
                    phase = mvp_pkg::PH_SYS;
                end
                mvp_pkg::PH_SYS:
                begin
                    fsys = b;
                    crc = crc_fold(crc, b);
                    phase = mvp_pkg::PH_COMP;
                end
                mvp_pkg::PH_COMP:
                begin
                    fcomp = b;
                    crc = crc_fold(crc, b);
                    phase = mvp_pkg::PH_MID0;
                end
                mvp_pkg::PH_MID0:
                begin
                    fmsg = {16'h0000, b};
                    crc = crc_fold(crc, b);
                    phase = mvp_pkg::PH_MID1;
                end
                mvp_pkg::PH_MID1:
                begin
                    fmsg[15:8] = b;
                    crc = crc_fold(crc, b);
                    phase = mvp_pkg::PH_MID2;
                end
                mvp_pkg::PH_MID2:
                begin
                    fmsg[23:16] = b;
                    crc = crc_fold(crc, b);
                    phase = (flen == 8'd0) ? mvp_pkg::PH_CRCLO : mvp_pkg::PH_PAYLOAD;
                end
                mvp_pkg::PH_PAYLOAD:
                begin
                    // only param1 and the command word are kept
                    if (pidx < mvp_pkg::PARAM_BYTES)
                        param = param | (32'(b) << (8 * pidx));
                    else if (pidx == mvp_pkg::CMD_OFFSET)
                        cmd[7:0] = b;
                    else if (pidx == mvp_pkg::CMD_OFFSET + 8'd1)
                        cmd[15:8] = b;
                    crc = crc_fold(crc, b);
                    if ({1'b0, pidx} + 9'd1 >= {1'b0, flen})
                        phase = mvp_pkg::PH_CRCLO;
                    pidx = pidx + 8'd1;
                end
                mvp_pkg::PH_CRCLO:
                begin
                    c = crc_fold(crc, extra_byte(fmsg));
                    if (c[7:0] != b)
                        phase = mvp_pkg::PH_IDLE;
                    else
                    begin
                        crc = c;
                        phase = mvp_pkg::PH_CRCHI;
                    end
                end
                mvp_pkg::PH_CRCHI:
                begin
                    if (crc[15:8] == b)
                    begin
                        d.msg = fmsg;
                        d.seq = fseq;
                        d.sys = fsys;
                        d.comp = fcomp;
                        d.len = flen;
                        d.cmd_ok = (fmsg == mvp_pkg::CMD_LONG_ID)
                                   && (flen >= mvp_pkg::CMD_MIN_LEN);
                        d.cmd = d.cmd_ok ? cmd : 16'h0000;
                        d.param = d.cmd_ok ? param : 32'h0;
                        expected_q.push_back(d);
                    end
                    phase = mvp_pkg::PH_IDLE;
                end
                default:
                begin
                    // hunting: only the start byte opens a frame
                    phase = mvp_pkg::PH_IDLE;
                    if (b == mvp_pkg::START_BYTE)
                    begin
                        crc = mvp_pkg::CRC_SEED;
                        pidx = '0;
                        fmsg = '0;
                        cmd = '0;
                        param = '0;
                        phase = mvp_pkg::PH_LEN;
                    end
                end
            endcase
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            error_count++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        endtask

        // compare one emitted descriptor with the oldest prediction
        task check_descriptor(descriptor_t got);
            descriptor_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("descriptor with no prediction, message_id 0x%0h", got.msg));
                return;
            end
            want = expected_q.pop_front();
            compare_field("message_id", 32'(got.msg), 32'(want.msg));
            compare_field("sequence_res", 32'(got.seq), 32'(want.seq));
            compare_field("sender_system", 32'(got.sys), 32'(want.sys));
            compare_field("sender_component", 32'(got.comp), 32'(want.comp));
            compare_field("payload_length", 32'(got.len), 32'(want.len));
            compare_field("command_valid", 32'(got.cmd_ok), 32'(want.cmd_ok));
            compare_field("command_code", 32'(got.cmd), 32'(want.cmd));
            compare_field("param1_bits", got.param, want.param);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [23:0] message_id;
    logic [7:0]  sequence_res;
    logic [7:0]  sender_system;
    logic [7:0]  sender_component;
    logic [7:0]  payload_length;
    logic        command_valid;
    logic [15:0] command_code;
    logic [31:0] param1_bits;

    frame_scoreboard sb = new();
    logic [7:0]      link_q[$];
    int              burst_left = 0;
    int              frame_bytes = 0;

    mavlink_v2_frame_parser_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .message_id       (message_id),
        .sequence_res     (sequence_res),
        .sender_system    (sender_system),
        .sender_component (sender_component),
        .payload_length   (payload_length),
        .command_valid    (command_valid),
        .command_code     (command_code),
        .param1_bits      (param1_bits)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // one request on the input side, with burst gaps; called at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        in_valid = 1'b1;
        rx_byte = b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b);
        burst_left--;
        @(negedge clk);
    endtask

    // push the staged link bytes out
    task automatic send_link(input bit framed);
        if (framed)
            frame_bytes += link_q.size();
        foreach (link_q[i])
            send_byte(link_q[i]);
        link_q.delete();
    endtask

    // stop sending until every predicted descriptor has come out
    task automatic hold_until_drained();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stage one frame, possibly damaged, on the link
    task automatic build_frame(input logic [7:0] len, input logic [7:0] seq,
                               input logic [7:0] sys, input logic [7:0] comp,
                               input logic [23:0] id, input fault_t fault);
        logic [7:0]  body[$];
        logic [15:0] crc;
        logic [7:0]  lo;
        logic [7:0]  hi;
        int          pos;
        body.push_back(len);
        body.push_back(8'($urandom));
        body.push_back(8'($urandom));
        body.push_back(seq);
        body.push_back(sys);
        body.push_back(comp);
        body.push_back(id[7:0]);
        body.push_back(id[15:8]);
        body.push_back(id[23:16]);
        repeat (len) body.push_back(8'($urandom));
        crc = mvp_pkg::CRC_SEED;
        foreach (body[i])
            crc = sb.crc_fold(crc, body[i]);
        crc = sb.crc_fold(crc, sb.extra_byte(id));
        lo = crc[7:0];
        hi = crc[15:8];
        case (fault)
            FAULT_LOW:       lo = lo ^ 8'($urandom_range(1, 255));
            FAULT_LOW_START: lo = mvp_pkg::START_BYTE;
            FAULT_HIGH:      hi = hi ^ 8'($urandom_range(1, 255));
            default:         ;
        endcase
        link_q.push_back(mvp_pkg::START_BYTE);
        foreach (body[i])
            link_q.push_back(body[i]);
        link_q.push_back(lo);
        link_q.push_back(hi);
        if (fault == FAULT_FLIP)
        begin
            pos = $urandom_range(1, link_q.size() - 1);
            link_q[pos] = link_q[pos] ^ (8'd1 << $urandom_range(0, 7));
        end
        else if (fault == FAULT_CUT)
        begin
            pos = $urandom_range(1, link_q.size() - 1);
            while (link_q.size() > pos)
                void'(link_q.pop_back());
        end
    endtask

    // mostly random, sometimes an extreme value
    function automatic logic [7:0] header_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // output side: randomly chosen stall modes and patterns
    initial
    begin
        int          sink_mode;
        int          sink_tick;
        logic [15:0] sink_pattern;
        out_ready = 1'b0;
        sink_mode = 0;
        sink_tick = 0;
        sink_pattern = '1;
        forever
        begin
            @(negedge clk);
            if (sink_tick % 64 == 0)
            begin
                sink_mode = $urandom_range(0, 3);
                sink_pattern = 16'($urandom);
            end
            case (sink_mode)
                0:       out_ready = 1'b1;
                1:       out_ready = 1'($urandom_range(0, 1));
                2:       out_ready = (sink_tick % 12 == 0);
                default: out_ready = sink_pattern[sink_tick % 16];
            endcase
            sink_tick++;
        end
    end

    // take emitted descriptors
    always @(posedge clk)
    begin : take_result
        descriptor_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen.msg = message_id;
            seen.seq = sequence_res;
            seen.sys = sender_system;
            seen.comp = sender_component;
            seen.len = payload_length;
            seen.cmd_ok = command_valid;
            seen.cmd = command_code;
            seen.param = param1_bits;
            sb.check_descriptor(seen);
        end
    end

    // stimulus
    initial
    begin
        logic [23:0] known_ids[7];
        logic [7:0]  len;
        logic [23:0] id;
        fault_t      fault;
        int          pick;
        int          next_hold;
        known_ids = '{MSG_HEARTBEAT, MSG_GPS_RAW, MSG_ATTITUDE, MSG_GLOBAL_POS,
                      MSG_RC_CHANNELS, mvp_pkg::CMD_LONG_ID, MSG_BATTERY};
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'h00;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // line noise while hunting, then an empty payload
        link_q = '{8'h00, 8'hFF, 8'hFE, 8'h7F};
        send_link(1'b0);
        build_frame(8'd0, 8'h00, 8'h00, 8'h00, MSG_HEARTBEAT, FAULT_NONE);
        send_link(1'b1);
        build_frame(8'd1, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF, FAULT_NONE);
        send_link(1'b1);
        // every id with a known extra byte
        foreach (known_ids[i])
        begin
            build_frame(8'($urandom_range(1, 9)), header_byte(), header_byte(),
                        header_byte(), known_ids[i], FAULT_NONE);
            send_link(1'b1);
        end
        // command frames around the minimum length
        build_frame(mvp_pkg::CMD_MIN_LEN, 8'h01, 8'h02, 8'h03,
                    mvp_pkg::CMD_LONG_ID, FAULT_NONE);
        send_link(1'b1);
        build_frame(mvp_pkg::CMD_MIN_LEN - 8'd1, 8'h04, 8'h05, 8'h06,
                    mvp_pkg::CMD_LONG_ID, FAULT_NONE);
        send_link(1'b1);
        build_frame(8'd3, 8'h07, 8'h08, 8'h09, mvp_pkg::CMD_LONG_ID, FAULT_NONE);
        send_link(1'b1);
        build_frame(8'd255, 8'h0A, 8'h0B, 8'h0C, mvp_pkg::CMD_LONG_ID, FAULT_NONE);
        send_link(1'b1);
        // low crc mismatch carrying the start byte value, then a good frame
        build_frame(8'd2, 8'h10, 8'h11, 8'h12, MSG_ATTITUDE, FAULT_LOW_START);
        send_link(1'b1);
        build_frame(8'd2, 8'h13, 8'h14, 8'h15, MSG_ATTITUDE, FAULT_NONE);
        send_link(1'b1);
        // high crc mismatch
        build_frame(8'd4, 8'h16, 8'h17, 8'h18, MSG_GPS_RAW, FAULT_HIGH);
        send_link(1'b1);
        build_frame(8'd33, 8'h19, 8'h1A, 8'h1B, mvp_pkg::CMD_LONG_ID, FAULT_NONE);
        send_link(1'b1);
        hold_until_drained();

        // random frames, mostly well formed
        next_hold = frame_bytes + 300;
        while (frame_bytes < FRAME_BYTE_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                repeat ($urandom_range(1, 4)) link_q.push_back(8'($urandom));
                send_link(1'b0);
            end
            else
            begin
                if (pick < 14)
                    fault = FAULT_FLIP;
                else if (pick < 18)
                    fault = FAULT_LOW;
                else if (pick < 21)
                    fault = FAULT_LOW_START;
                else if (pick < 24)
                    fault = FAULT_HIGH;
                else if (pick < 27)
                    fault = FAULT_CUT;
                else
                    fault = FAULT_NONE;
                case ($urandom_range(0, 19))
                    0, 1:    len = 8'd0;
                    2:       len = 8'($urandom_range(32, 255));
                    default: len = 8'($urandom_range(1, 40));
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: id = known_ids[$urandom_range(0, 6)];
                    4, 5:
                    begin
                        id = mvp_pkg::CMD_LONG_ID;
                        len = 8'($urandom_range(28, 40));
                    end
                    6:       id = 24'($urandom_range(0, 255));
                    default: id = 24'($urandom);
                endcase
                build_frame(len, header_byte(), header_byte(), header_byte(), id, fault);
                send_link(1'b1);
            end
            if (frame_bytes >= next_hold)
            begin
                hold_until_drained();
                next_hold = frame_bytes + 300;
            end
        end

        // drain and finish
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
